// File: src/fatcw_pkg.sv
package fatcw_pkg;

    // Command codes carried in the action field.
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_ADVANCE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_LOW      = 2'd1;
    localparam logic [1:0] STAT_NO_CHAIN = 2'd2;

    // Configuration register indexes (byte address divided by four).
    localparam logic [2:0] REG_RESERVED   = 3'd0;
    localparam logic [2:0] REG_FAT_SECS   = 3'd1;
    localparam logic [2:0] REG_FAT_COPIES = 3'd2;
    localparam logic [2:0] REG_ROOT_ENTS  = 3'd3;
    localparam logic [2:0] REG_SECT_LOG2  = 3'd4;
    localparam logic [2:0] REG_CLUS_SECS  = 3'd5;

    localparam logic [11:0] ENTRY_MASK    = 12'h0FFF;
    localparam logic [11:0] CHAIN_END_MIN = 12'h0FF8;

    localparam logic [3:0] SECT_LOG2_MIN = 4'd9;
    localparam logic [3:0] SECT_LOG2_MAX = 4'd12;

    typedef struct packed {
        logic [1:0]  action;
        logic [12:0] table_address;
        logic [7:0]  table_byte;
        logic [11:0] start_cluster;
    } t_cmd;

    typedef struct packed {
        logic [11:0] cluster_number;
        logic [31:0] sector_address;
        logic [11:0] next_cluster;
        logic        chain_end;
        logic [1:0]  status;
    } t_result;

endpackage

// File: src/fat12_cluster_chain_walker.sv
// Channel   Direction  Handshake                      Payload
// command   in         start, busy (taken: !busy)     i_cmd (fatcw_pkg::t_cmd)
// result    out        o_done, one cycle, no stall    o_result (fatcw_pkg::t_result)
// config    in/out     APB psel/penable/pwrite        paddr, pwdata, prdata, pready
//
// A load leaves busy low; the byte is written at the accepting edge.
// A start or advance reads the FAT, held in two byte-wide banks (even and
// odd offsets), read together in the accept cycle; the result leaves on the next cycle.
// Reset clears the chain state and loads the default volume geometry; FAT bytes are
// undefined until loaded. The receiver cannot stall, so busy depends only on the walker.
module fat12_cluster_chain_walker #(
    parameter int FAT_STORE_BYTES = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  fatcw_pkg::t_cmd   i_cmd,
    output logic              o_done,
    output fatcw_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // An odd store size leaves its last byte in the even bank.
    localparam int BANK_DEPTH = (FAT_STORE_BYTES + 1) / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_RESULT = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_reserved;
    logic [15:0] r_fat_secs;
    logic [2:0]  r_fat_copies;
    logic [15:0] r_root_ents;
    logic [3:0]  r_sect_log2;
    logic [7:0]  r_clus_secs;

    logic [11:0] r_pending;
    logic        r_chain_active;

    logic [11:0] r_cluster;
    logic [1:0]  r_status;
    logic        r_idx_odd;
    logic        r_lo_ok;
    logic        r_hi_ok;
    logic [31:0] r_base;
    logic [19:0] r_offset;

    logic        w_accept;
    logic        w_chain_cmd;
    logic        w_cfg_write;
    logic [11:0] w_cluster;
    logic [1:0]  w_status;
    logic [13:0] w_triple;
    logic [12:0] w_idx;
    logic [13:0] w_idx1;
    logic [31:0] w_even_raddr;
    logic [31:0] w_odd_raddr;
    logic [31:0] w_waddr;
    logic        w_load_we;
    logic [11:0] w_cm2;
    logic [18:0] w_fat_total;
    logic [3:0]  w_shift;
    logic [21:0] w_root_round;
    logic [13:0] w_root_secs;
    logic [31:0] w_base;
    logic [7:0]  w_even_rd;
    logic [7:0]  w_odd_rd;
    logic [7:0]  w_lo;
    logic [7:0]  w_hi;
    logic [11:0] w_entry;
    logic        w_end;

    assign busy        = (r_state == ST_RESULT);
    assign w_accept    = start && !busy;
    assign w_chain_cmd = w_accept
                         && (i_cmd.action == fatcw_pkg::ACT_START
                             || i_cmd.action == fatcw_pkg::ACT_ADVANCE);
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign pready      = 1'b1;

    // Cluster and status chosen at the accepting edge.
    always_comb begin
        w_cluster = (i_cmd.action == fatcw_pkg::ACT_START) ? i_cmd.start_cluster
                                                           : r_pending;
        if (i_cmd.action == fatcw_pkg::ACT_ADVANCE && !r_chain_active) begin
            w_status  = fatcw_pkg::STAT_NO_CHAIN;
            w_cluster = 12'd0;
        end else if (w_cluster < 12'd2) begin
            w_status = fatcw_pkg::STAT_LOW;
        end else begin
            w_status = fatcw_pkg::STAT_OK;
        end
    end

    // Entry byte offset is cluster * 3 / 2; its two bytes sit in opposite banks.
    assign w_triple     = {1'b0, w_cluster, 1'b0} + {2'b00, w_cluster};
    assign w_idx        = w_triple[13:1];
    assign w_idx1       = {1'b0, w_idx} + 14'd1;
    assign w_even_raddr = 32'(w_idx1[13:1]);
    assign w_odd_raddr  = 32'(w_idx[12:1]);

    assign w_waddr   = 32'(i_cmd.table_address[12:1]);
    assign w_load_we = w_accept && (i_cmd.action == fatcw_pkg::ACT_LOAD)
                       && (32'(i_cmd.table_address) < 32'(FAT_STORE_BYTES));

    // Data region start: reserved + FAT copies + rounded-up root directory.
    assign w_fat_total  = 19'(r_fat_secs) * 19'(r_fat_copies);
    assign w_shift      = (r_sect_log2 < fatcw_pkg::SECT_LOG2_MIN) ? fatcw_pkg::SECT_LOG2_MIN :
                          (r_sect_log2 > fatcw_pkg::SECT_LOG2_MAX) ? fatcw_pkg::SECT_LOG2_MAX :
                          r_sect_log2;
    assign w_root_round = {1'b0, r_root_ents, 5'b00000} + ((22'd1 << w_shift) - 22'd1);
    assign w_root_secs  = 14'(w_root_round >> w_shift);
    assign w_base       = 32'(r_reserved) + 32'(w_fat_total) + 32'(w_root_secs);
    assign w_cm2        = w_cluster - 12'd2;

    fatcw_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (w_load_we && !i_cmd.table_address[0]),
        .i_waddr (w_waddr[BANK_AW-1:0]),
        .i_wdata (i_cmd.table_byte),
        .i_raddr (w_even_raddr[BANK_AW-1:0]),
        .o_rdata (w_even_rd)
    );

    fatcw_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (w_load_we && i_cmd.table_address[0]),
        .i_waddr (w_waddr[BANK_AW-1:0]),
        .i_wdata (i_cmd.table_byte),
        .i_raddr (w_odd_raddr[BANK_AW-1:0]),
        .o_rdata (w_odd_rd)
    );

    // Bytes past the end of the store read as zero.
    always_comb begin
        w_lo = r_idx_odd ? w_odd_rd : w_even_rd;
        w_hi = r_idx_odd ? w_even_rd : w_odd_rd;
        if (!r_lo_ok) begin
            w_lo = 8'd0;
        end
        if (!r_hi_ok) begin
            w_hi = 8'd0;
        end
        w_entry = r_cluster[0] ? {w_hi, w_lo[7:4]} : {w_hi[3:0], w_lo};
        w_entry = w_entry & fatcw_pkg::ENTRY_MASK;
        w_end   = (w_entry >= fatcw_pkg::CHAIN_END_MIN);
    end

    always_comb begin
        o_done   = busy;
        o_result = '0;
        o_result.cluster_number = r_cluster;
        o_result.status         = r_status;
        if (r_status == fatcw_pkg::STAT_OK) begin
            o_result.sector_address = r_base + 32'(r_offset);
            o_result.next_cluster   = w_entry;
            o_result.chain_end      = w_end;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_chain_cmd) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_pending      <= 12'd0;
            r_chain_active <= 1'b0;
        end else begin
            r_state <= n_state;
            if (busy) begin
                if (r_status == fatcw_pkg::STAT_LOW) begin
                    r_chain_active <= 1'b0;
                end else if (r_status == fatcw_pkg::STAT_OK) begin
                    if (w_end) begin
                        r_chain_active <= 1'b0;
                    end else begin
                        r_pending      <= w_entry;
                        r_chain_active <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_chain_cmd) begin
            r_cluster <= w_cluster;
            r_status  <= w_status;
            r_idx_odd <= w_idx[0];
            r_lo_ok   <= (32'(w_idx) < 32'(FAT_STORE_BYTES));
            r_hi_ok   <= (32'(w_idx1) < 32'(FAT_STORE_BYTES));
            r_base    <= w_base;
            r_offset  <= 20'(w_cm2) * 20'(r_clus_secs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved   <= 16'd1;
            r_fat_secs   <= 16'd9;
            r_fat_copies <= 3'd2;
            r_root_ents  <= 16'd224;
            r_sect_log2  <= 4'd9;
            r_clus_secs  <= 8'd1;
        end else if (w_cfg_write) begin
            unique case (paddr[4:2])
                fatcw_pkg::REG_RESERVED:   r_reserved   <= pwdata[15:0];
                fatcw_pkg::REG_FAT_SECS:   r_fat_secs   <= pwdata[15:0];
                fatcw_pkg::REG_FAT_COPIES: r_fat_copies <= pwdata[2:0];
                fatcw_pkg::REG_ROOT_ENTS:  r_root_ents  <= pwdata[15:0];
                fatcw_pkg::REG_SECT_LOG2:  r_sect_log2  <= pwdata[3:0];
                fatcw_pkg::REG_CLUS_SECS:  r_clus_secs  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            fatcw_pkg::REG_RESERVED:   prdata = 32'(r_reserved);
            fatcw_pkg::REG_FAT_SECS:   prdata = 32'(r_fat_secs);
            fatcw_pkg::REG_FAT_COPIES: prdata = 32'(r_fat_copies);
            fatcw_pkg::REG_ROOT_ENTS:  prdata = 32'(r_root_ents);
            fatcw_pkg::REG_SECT_LOG2:  prdata = 32'(r_sect_log2);
            fatcw_pkg::REG_CLUS_SECS:  prdata = 32'(r_clus_secs);
            default:                   prdata = 32'd0;
        endcase
    end

    a_single_result_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("walker stayed busy for more than one cycle");

    a_done_follows_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy
                         && (i_cmd.action == fatcw_pkg::ACT_START
                             || i_cmd.action == fatcw_pkg::ACT_ADVANCE)))
        else $error("result without a start or advance command");

    a_end_closes_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.chain_end) |=> !r_chain_active)
        else $error("chain still active after an end-of-chain result");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != fatcw_pkg::STAT_OK)
        |-> (o_result.sector_address == 32'd0 && o_result.next_cluster == 12'd0
             && !o_result.chain_end))
        else $error("error result carries nonzero payload");

endmodule

// File: src/fatcw_ram.sv
module fatcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
